>>> src/cdcs_pkg.sv
// shared types and constants of the card-detect calibration sequencer
package cdcs_pkg;

    // result action codes
    typedef enum logic [1:0] {
        ACT_IGNORE  = 2'd0,
        ACT_MEASURE = 2'd1,
        ACT_OK      = 2'd2,
        ACT_FAIL    = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [2:0] CFG_TIMER      = 3'd0;
    localparam logic [2:0] CFG_SHIFT      = 3'd1;
    localparam logic [2:0] CFG_REF_MIN    = 3'd2;
    localparam logic [2:0] CFG_REF_MAX    = 3'd3;
    localparam logic [2:0] CFG_INIT_ATTEN = 3'd4;
    localparam logic [2:0] CFG_INIT_AMP   = 3'd5;

    // highest amplification code
    localparam logic [2:0] AMP_MAX = 3'd7;

    // configuration register set
    typedef struct packed {
        logic [4:0] timer_setting;
        logic [2:0] threshold_shift;
        logic [6:0] reference_min;
        logic [6:0] reference_max;
        logic [1:0] init_atten;
        logic [2:0] init_amp;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_action    action;
        logic [1:0] attenuation;
        logic [2:0] amplification;
        logic [6:0] reference;
        logic [7:0] center;
        logic [7:0] low_thr;
        logic [7:0] high_thr;
        logic [1:0] divider;
    } t_result;

endpackage

>>> src/cdcs_cfg.sv
// configuration register file of the calibration sequencer
module cdcs_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output cdcs_pkg::t_cfg o_cfg
);
    import cdcs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timer_setting   <= 5'd11;
            r_cfg.threshold_shift <= 3'd4;
            r_cfg.reference_min   <= 7'd0;
            r_cfg.reference_max   <= 7'd127;
            r_cfg.init_atten      <= 2'd3;
            r_cfg.init_amp        <= 3'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMER:      r_cfg.timer_setting   <= i_cfg_data[4:0];
                CFG_SHIFT:      r_cfg.threshold_shift <= i_cfg_data[2:0];
                CFG_REF_MIN:    r_cfg.reference_min   <= i_cfg_data[6:0];
                CFG_REF_MAX:    r_cfg.reference_max   <= i_cfg_data[6:0];
                CFG_INIT_ATTEN: r_cfg.init_atten      <= i_cfg_data[1:0];
                CFG_INIT_AMP:   r_cfg.init_amp        <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/cdcs_core.sv
// calibration state machine with its result register
module cdcs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic               i_func,
    input  logic [7:0]         i_adc,
    input  cdcs_pkg::t_cfg     i_cfg,
    input  logic               i_out_stall,
    output logic               o_out_free,
    output logic               o_out_valid,
    output cdcs_pkg::t_result  o_result
);
    import cdcs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FIRST, PH_REDUCE, PH_REFMAX, PH_AMPLIFY, PH_SWEEP
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [1:0] r_atten,  n_atten;
    logic [2:0] r_amp,    n_amp;
    logic [6:0] r_ref,    n_ref;
    logic [7:0] r_center, n_center;
    logic [7:0] r_thr,    n_thr;
    logic [7:0] r_prev,   n_prev;
    logic [1:0] r_div,    n_div;
    t_action    n_action;
    logic       r_out_valid;
    t_result    r_result;

    logic [7:0] tm1;
    logic [7:0] full;
    logic [6:0] ref_inc;
    logic signed [9:0] below;
    logic signed [9:0] above;
    logic       sweep_ok;

    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // full scale from the timer setting
    assign tm1 = {3'd0, i_cfg.timer_setting} - 8'd1;
    always_comb begin
        if (i_cfg.timer_setting[4]) begin
            full = {tm1[4:0], 3'd0};
        end else if (i_cfg.timer_setting[3]) begin
            full = {tm1[3:0], 4'd0};
        end else begin
            full = {tm1[2:0], 5'd0};
        end
    end

    assign ref_inc  = r_ref + 7'd1;
    assign below    = $signed({2'b00, r_center}) - $signed({2'b00, i_adc});
    assign above    = $signed({2'b00, r_prev}) - $signed({2'b00, r_center});
    assign sweep_ok = i_cfg.reference_min < i_cfg.reference_max;

    // next state for one item
    always_comb begin
        n_phase  = r_phase;
        n_atten  = r_atten;
        n_amp    = r_amp;
        n_ref    = r_ref;
        n_center = r_center;
        n_thr    = r_thr;
        n_prev   = r_prev;
        n_div    = r_div;
        n_action = ACT_IGNORE;
        if (!i_func) begin
            // start: derive scale and load the initial gain
            if (i_cfg.timer_setting[4]) begin
                n_div = 2'd2;
            end else if (i_cfg.timer_setting[3]) begin
                n_div = 2'd1;
            end else begin
                n_div = 2'd0;
            end
            n_center = full >> 1;
            n_thr    = full >> i_cfg.threshold_shift;
            n_atten  = i_cfg.init_atten;
            n_amp    = i_cfg.init_amp;
            n_ref    = i_cfg.reference_min;
            n_phase  = PH_FIRST;
            n_action = ACT_MEASURE;
        end else begin
            unique case (r_phase)
                PH_FIRST, PH_REDUCE: begin
                    if (r_phase == PH_REDUCE && i_adc > r_center) begin
                        if (sweep_ok) begin
                            n_ref    = i_cfg.reference_min;
                            n_prev   = i_adc;
                            n_phase  = PH_SWEEP;
                            n_action = ACT_MEASURE;
                        end else begin
                            n_phase  = PH_IDLE;
                            n_action = ACT_FAIL;
                        end
                    end else if (r_phase == PH_FIRST && i_adc >= r_center) begin
                        n_ref    = i_cfg.reference_max;
                        n_phase  = PH_REFMAX;
                        n_action = ACT_MEASURE;
                    end else if (r_atten == 2'd0) begin
                        n_phase  = PH_IDLE;
                        n_action = ACT_FAIL;
                    end else begin
                        n_atten  = r_atten - 2'd1;
                        n_phase  = PH_REDUCE;
                        n_action = ACT_MEASURE;
                    end
                end
                PH_REFMAX, PH_AMPLIFY: begin
                    if ((r_phase == PH_REFMAX && i_adc <= r_center) ||
                        (r_phase == PH_AMPLIFY && i_adc < r_center)) begin
                        if (sweep_ok) begin
                            n_ref    = i_cfg.reference_min;
                            n_prev   = i_adc;
                            n_phase  = PH_SWEEP;
                            n_action = ACT_MEASURE;
                        end else begin
                            n_phase  = PH_IDLE;
                            n_action = ACT_FAIL;
                        end
                    end else if (r_amp == AMP_MAX) begin
                        n_phase  = PH_IDLE;
                        n_action = ACT_FAIL;
                    end else begin
                        n_amp    = r_amp + 3'd1;
                        n_phase  = PH_AMPLIFY;
                        n_action = ACT_MEASURE;
                    end
                end
                PH_SWEEP: begin
                    if (i_adc < r_center) begin
                        // keep whichever sample lies closer to center
                        if (below < above) begin
                            n_center = i_adc;
                        end else begin
                            n_center = r_prev;
                            n_ref    = r_ref - 7'd1;
                        end
                        n_phase  = PH_IDLE;
                        n_action = ACT_OK;
                    end else begin
                        n_prev = i_adc;
                        if (ref_inc < i_cfg.reference_max) begin
                            n_ref    = ref_inc;
                            n_action = ACT_MEASURE;
                        end else begin
                            n_ref    = i_cfg.reference_max;
                            n_phase  = PH_IDLE;
                            n_action = ACT_FAIL;
                        end
                    end
                end
                default: begin
                    n_phase  = PH_IDLE;
                    n_action = ACT_IGNORE;
                end
            endcase
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_atten     <= 2'd3;
            r_amp       <= 3'd0;
            r_ref       <= 7'd0;
            r_center    <= 8'd0;
            r_thr       <= 8'd0;
            r_prev      <= 8'd0;
            r_div       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_go) begin
                r_phase  <= n_phase;
                r_atten  <= n_atten;
                r_amp    <= n_amp;
                r_ref    <= n_ref;
                r_center <= n_center;
                r_thr    <= n_thr;
                r_prev   <= n_prev;
                r_div    <= n_div;
                r_out_valid            <= 1'b1;
                r_result.action        <= n_action;
                r_result.attenuation   <= n_atten;
                r_result.amplification <= n_amp;
                r_result.reference     <= n_ref;
                r_result.center        <= n_center;
                r_result.low_thr       <= n_center - n_thr;
                r_result.high_thr      <= n_center + n_thr;
                r_result.divider       <= n_div;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a processed item always leaves a result behind
    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |=> r_out_valid)
        else $error("processed item produced no result");

    // a finished calibration returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && (n_action == ACT_OK || n_action == ACT_FAIL)) |=> r_phase == PH_IDLE)
        else $error("sequencer not idle after done");

    // the sweep never reaches the top reference
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SWEEP |-> r_ref < i_cfg.reference_max)
        else $error("sweep reference out of range");

endmodule

>>> src/card_detect_calibration_sequencer.sv
// top level of the card-detect calibration sequencer
// Card-detect calibration sequencer. A start item (func 0) derives full scale,
// center, threshold and clock divider from the phase-3 timer setting and asks
// for a measurement; each measurement item (func 1) steps the gain search and
// then the reference sweep, and every item returns exactly one result carrying
// the action and the current gain, reference, center and thresholds. A result
// is presented once its item has passed the input register, where the step logic
// works on it, and then the result register; an output stall can hold the item
// in the input register. A new item is taken every cycle, limited only by the
// result register being held by output stall.
// Configuration is written through a separate valid/ready port that is always
// ready; write it only while no calibration is running.
module card_detect_calibration_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_func,
    input  logic [7:0] i_adc_value,
    // result items
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_action,
    output logic [1:0] o_attenuation,
    output logic [2:0] o_amplification,
    output logic [6:0] o_reference,
    output logic [7:0] o_center_value,
    output logic [7:0] o_low_threshold,
    output logic [7:0] o_high_threshold,
    output logic [1:0] o_clock_divider
);
    import cdcs_pkg::*;

    t_cfg       cfg;
    t_result    result;
    logic       out_free;
    logic       go;
    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_adc;

    cdcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register advances when the result side can take the step
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_func <= i_func;
            r_adc  <= i_adc_value;
        end
    end

    cdcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_func      (r_func),
        .i_adc       (r_adc),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    // result fields
    assign o_action         = result.action;
    assign o_attenuation    = result.attenuation;
    assign o_amplification  = result.amplification;
    assign o_reference      = result.reference;
    assign o_center_value   = result.center;
    assign o_low_threshold  = result.low_thr;
    assign o_high_threshold = result.high_thr;
    assign o_clock_divider  = result.divider;

endmodule

>>> bench/tb_card_detect_calibration_sequencer.sv
// self-checking testbench of the card-detect calibration sequencer
module tb_card_detect_calibration_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import cdcs_pkg::*;

    // item function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_MEASURE = 1'b1;

    localparam int ITEMS_PER_PHASE = 58;
    localparam int NUM_PHASES      = 9;
    localparam int LIMIT_CYCLES    = 200000;

    // calibration progress as seen by the predictor
    typedef enum logic [2:0] {
        CP_IDLE,
        CP_FIRST,
        CP_REDUCE,
        CP_REFMAX,
        CP_AMPLIFY,
        CP_SWEEP
    } t_calib_phase;

    // one directed stimulus row, optionally with a hand-written result
    typedef struct packed {
        logic       func;
        logic [7:0] adc;
        logic       fixed_valid;
        t_result    fixed_res;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_func;
    logic [7:0] i_adc_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_action;
    logic [1:0] o_attenuation;
    logic [2:0] o_amplification;
    logic [6:0] o_reference;
    logic [7:0] o_center_value;
    logic [7:0] o_low_threshold;
    logic [7:0] o_high_threshold;
    logic [1:0] o_clock_divider;

    // predictor copy of registers and state
    t_cfg         cfg_regs;
    t_calib_phase phase_q;
    logic [1:0]   atten_q;
    logic [2:0]   amp_q;
    logic [6:0]   ref_q;
    logic [7:0]   center_q;
    logic [7:0]   thr_q;
    logic [7:0]   prev_q;
    logic [1:0]   div_q;

    t_result   awaited_results[$];
    t_stim_row stim_table[$];
    int        mismatch_count = 0;
    int        burst_left = 0;
    bit        hold_off_pending = 1'b0;

    card_detect_calibration_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_adc_value      (i_adc_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_action         (o_action),
        .o_attenuation    (o_attenuation),
        .o_amplification  (o_amplification),
        .o_reference      (o_reference),
        .o_center_value   (o_center_value),
        .o_low_threshold  (o_low_threshold),
        .o_high_threshold (o_high_threshold),
        .o_clock_divider  (o_clock_divider)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
    endtask

    // enter the reference sweep, or fail when the sweep range is empty
    function automatic t_action begin_sweep(input logic [7:0] adc);
        if (cfg_regs.reference_min < cfg_regs.reference_max) begin
            ref_q   = cfg_regs.reference_min;
            prev_q  = adc;
            phase_q = CP_SWEEP;
            return ACT_MEASURE;
        end
        phase_q = CP_IDLE;
        return ACT_FAIL;
    endfunction

    // step the calibration by one item and return the result it causes
    function automatic t_result advance_calibration(input logic f, input logic [7:0] adc);
        t_result    r;
        t_action    act;
        logic [7:0] tm1;
        logic [7:0] full;
        int         below;
        int         above;
        act = ACT_IGNORE;
        if (f == FUNC_START) begin
            // full scale and divider from the timer setting, 8-bit wrap
            tm1 = {3'b000, cfg_regs.timer_setting} - 8'd1;
            if (cfg_regs.timer_setting > 5'd15) begin
                div_q = 2'd2;
                full  = tm1 << 3;
            end else if (cfg_regs.timer_setting > 5'd7) begin
                div_q = 2'd1;
                full  = tm1 << 4;
            end else begin
                div_q = 2'd0;
                full  = tm1 << 5;
            end
            center_q = full >> 1;
            thr_q    = full >> cfg_regs.threshold_shift;
            atten_q  = cfg_regs.init_atten;
            amp_q    = cfg_regs.init_amp;
            ref_q    = cfg_regs.reference_min;
            phase_q  = CP_FIRST;
            act      = ACT_MEASURE;
        end else begin
            case (phase_q)
                // attenuation search
                CP_FIRST, CP_REDUCE: begin
                    if (phase_q == CP_REDUCE && adc > center_q) begin
                        act = begin_sweep(adc);
                    end else if (phase_q == CP_FIRST && adc >= center_q) begin
                        ref_q   = cfg_regs.reference_max;
                        phase_q = CP_REFMAX;
                        act     = ACT_MEASURE;
                    end else if (atten_q == 2'd0) begin
                        phase_q = CP_IDLE;
                        act     = ACT_FAIL;
                    end else begin
                        atten_q = atten_q - 2'd1;
                        phase_q = CP_REDUCE;
                        act     = ACT_MEASURE;
                    end
                end
                // amplification search at the top reference
                CP_REFMAX, CP_AMPLIFY: begin
                    if ((phase_q == CP_REFMAX && adc <= center_q) ||
                        (phase_q == CP_AMPLIFY && adc < center_q)) begin
                        act = begin_sweep(adc);
                    end else if (amp_q >= AMP_MAX) begin
                        phase_q = CP_IDLE;
                        act     = ACT_FAIL;
                    end else begin
                        amp_q   = amp_q + 3'd1;
                        phase_q = CP_AMPLIFY;
                        act     = ACT_MEASURE;
                    end
                end
                // reference sweep, closer sample becomes the center
                CP_SWEEP: begin
                    if (adc < center_q) begin
                        below = int'(center_q) - int'(adc);
                        above = int'(prev_q) - int'(center_q);
                        if (below < above) begin
                            center_q = adc;
                        end else begin
                            center_q = prev_q;
                            ref_q    = ref_q - 7'd1;
                        end
                        phase_q = CP_IDLE;
                        act     = ACT_OK;
                    end else begin
                        prev_q = adc;
                        ref_q  = ref_q + 7'd1;
                        if (ref_q < cfg_regs.reference_max) begin
                            act = ACT_MEASURE;
                        end else begin
                            ref_q   = cfg_regs.reference_max;
                            phase_q = CP_IDLE;
                            act     = ACT_FAIL;
                        end
                    end
                end
                default: begin
                    phase_q = CP_IDLE;
                    act     = ACT_IGNORE;
                end
            endcase
        end
        r.action        = act;
        r.attenuation   = atten_q;
        r.amplification = amp_q;
        r.reference     = ref_q;
        r.center        = center_q;
        r.low_thr       = center_q - thr_q;
        r.high_thr      = center_q + thr_q;
        r.divider       = div_q;
        return r;
    endfunction

    function automatic t_result known_result(input t_action act, input logic [1:0] at,
                                             input logic [2:0] am, input logic [6:0] rf,
                                             input logic [7:0] c, input logic [7:0] lo,
                                             input logic [7:0] hi, input logic [1:0] dv);
        t_result r;
        r.action        = act;
        r.attenuation   = at;
        r.amplification = am;
        r.reference     = rf;
        r.center        = c;
        r.low_thr       = lo;
        r.high_thr      = hi;
        r.divider       = dv;
        return r;
    endfunction

    task automatic add_row(input logic f, input logic [7:0] a, input logic fixed_valid,
                           input t_result fixed_res);
        t_stim_row row;
        row.func        = f;
        row.adc         = a;
        row.fixed_valid = fixed_valid;
        row.fixed_res   = fixed_res;
        stim_table.push_back(row);
    endtask

    // samples strictly below, or at and above, the predicted center
    function automatic logic [7:0] sample_below();
        if (center_q == 8'd0)
            return 8'd0;
        if ($urandom_range(0, 1) == 0)
            return center_q - 8'($urandom_range(1, (center_q < 8'd4) ? center_q : 4));
        return 8'($urandom_range(0, center_q - 1));
    endfunction

    function automatic logic [7:0] sample_at_or_above();
        if ($urandom_range(0, 1) == 0)
            return center_q + 8'($urandom_range(0, ((255 - center_q) < 3) ? (255 - center_q) : 3));
        return 8'($urandom_range(center_q, 255));
    endfunction

    // offer one item in bursts with random gaps; predict once it transfers
    task automatic send_item(input logic f, input logic [7:0] a, input logic fixed_valid,
                             input t_result fixed_res);
        t_result predicted;
        if (burst_left == 0) begin
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_adc_value <= a;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = advance_calibration(f, a);
        awaited_results.push_back(fixed_valid ? fixed_res : predicted);
        burst_left--;
        if (burst_left == 0)
            i_in_valid <= 1'b0;
    endtask

    // drop valid and let every awaited result come back
    task automatic wait_idle();
        if (burst_left != 0) begin
            burst_left = 0;
            i_in_valid <= 1'b0;
        end
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // valid stays high across a batch of writes
    task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_TIMER:      cfg_regs.timer_setting   = data[4:0];
            CFG_SHIFT:      cfg_regs.threshold_shift = data[2:0];
            CFG_REF_MIN:    cfg_regs.reference_min   = data[6:0];
            CFG_REF_MAX:    cfg_regs.reference_max   = data[6:0];
            CFG_INIT_ATTEN: cfg_regs.init_atten      = data[1:0];
            CFG_INIT_AMP:   cfg_regs.init_amp        = data[2:0];
            default: ;
        endcase
    endtask

    // result checking against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_error("result transfer with no expectation waiting");
            end else begin
                want = awaited_results.pop_front();
                check_field("action", 8'(o_action), 8'(want.action));
                check_field("attenuation", 8'(o_attenuation), 8'(want.attenuation));
                check_field("amplification", 8'(o_amplification), 8'(want.amplification));
                check_field("reference", 8'(o_reference), 8'(want.reference));
                check_field("center", o_center_value, want.center);
                check_field("low threshold", o_low_threshold, want.low_thr);
                check_field("high threshold", o_high_threshold, want.high_thr);
                check_field("clock divider", 8'(o_clock_divider), 8'(want.divider));
            end
        end
    end

    // receiver stall pattern in segments, plus one long hold-off on request
    initial begin : receiver
        int seg_len;
        int stall_pct;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                seg_len   = 60;
                stall_pct = 100;
            end else begin
                seg_len = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            repeat (seg_len) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("tb_card_detect_calibration_sequencer: errors");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int         phase_items;
        logic [4:0] t_set;
        logic [2:0] shift_set;
        logic [6:0] rmin_set;
        logic [6:0] rmax_set;
        logic [1:0] atten_set;
        logic [2:0] amp_set;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TIMER;
        i_cfg_data  <= 8'd0;
        i_in_valid  <= 1'b0;
        i_func      <= FUNC_START;
        i_adc_value <= 8'd0;

        // register and state values after reset
        cfg_regs.timer_setting   = 5'd11;
        cfg_regs.threshold_shift = 3'd4;
        cfg_regs.reference_min   = 7'd0;
        cfg_regs.reference_max   = 7'd127;
        cfg_regs.init_atten      = 2'd3;
        cfg_regs.init_amp        = 3'd0;
        phase_q  = CP_IDLE;
        atten_q  = 2'd3;
        amp_q    = 3'd0;
        ref_q    = 7'd0;
        center_q = 8'd0;
        thr_q    = 8'd0;
        prev_q   = 8'd0;
        div_q    = 2'd0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // measurement while idle right after reset
        add_row(FUNC_MEASURE, 8'hFF, 1'b1,
                known_result(ACT_IGNORE, 2'd3, 3'd0, 7'd0, 8'd0, 8'd0, 8'd0, 2'd0));
        // start at reset settings: full scale 160, center 80, threshold 10
        add_row(FUNC_START, 8'h00, 1'b1,
                known_result(ACT_MEASURE, 2'd3, 3'd0, 7'd0, 8'd80, 8'd70, 8'd90, 2'd1));
        // attenuation stepped down to zero, then failure
        add_row(FUNC_MEASURE, 8'd0, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd80, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd0, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd0, 1'b1,
                known_result(ACT_FAIL, 2'd0, 3'd0, 7'd0, 8'd80, 8'd70, 8'd90, 2'd1));
        // amplification stepped up to its limit, then failure
        add_row(FUNC_START, 8'hFF, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd255, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd255, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd81, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd100, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd200, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd255, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd90, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd81, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd80, 1'b1,
                known_result(ACT_FAIL, 2'd3, 3'd7, 7'd127, 8'd80, 8'd70, 8'd90, 2'd1));
        // sweep where the current sample is closer
        add_row(FUNC_START, 8'h55, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd80, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd80, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd200, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd0, 1'b0, '0);
        // sweep where the previous sample wins and the reference wraps back
        add_row(FUNC_START, 8'hAA, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd255, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd0, 1'b0, '0);
        add_row(FUNC_MEASURE, 8'd79, 1'b0, '0);

        foreach (stim_table[k])
            send_item(stim_table[k].func, stim_table[k].adc,
                      stim_table[k].fixed_valid, stim_table[k].fixed_res);

        // random calibration runs, one register setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    t_set = 5'd31; shift_set = 3'd7; rmin_set = 7'd0; rmax_set = 7'd127;
                    atten_set = 2'd3; amp_set = 3'd0;
                end
                1: begin
                    t_set = 5'd2; shift_set = 3'd0; rmin_set = 7'd127; rmax_set = 7'd0;
                    atten_set = 2'd0; amp_set = 3'd7;
                end
                2: begin
                    t_set = 5'd0; shift_set = 3'd1; rmin_set = 7'd20; rmax_set = 7'd24;
                    atten_set = 2'd1; amp_set = 3'd6;
                end
                3: begin
                    t_set = 5'd1; shift_set = 3'd5; rmin_set = 7'd60; rmax_set = 7'd60;
                    atten_set = 2'd2; amp_set = 3'd3;
                end
                default: begin
                    t_set     = 5'($urandom_range(0, 31));
                    shift_set = 3'($urandom());
                    atten_set = 2'($urandom());
                    amp_set   = 3'($urandom());
                    case ($urandom_range(0, 3))
                        0: begin
                            rmin_set = 7'd0;
                            rmax_set = 7'd127;
                        end
                        1: begin
                            rmin_set = 7'($urandom_range(0, 120));
                            rmax_set = rmin_set + 7'($urandom_range(1, 6));
                        end
                        2: begin
                            rmax_set = 7'($urandom_range(0, 127));
                            rmin_set = 7'($urandom_range(rmax_set, 127));
                        end
                        default: begin
                            rmin_set = 7'($urandom());
                            rmax_set = 7'($urandom());
                        end
                    endcase
                end
            endcase

            wait_idle();
            write_register(CFG_TIMER, {3'b000, t_set});
            write_register(CFG_SHIFT, {5'b00000, shift_set});
            write_register(CFG_REF_MIN, {1'b0, rmin_set});
            write_register(CFG_REF_MAX, {1'b0, rmax_set});
            write_register(CFG_INIT_ATTEN, {6'b000000, atten_set});
            write_register(CFG_INIT_AMP, {5'b00000, amp_set});
            i_cfg_valid <= 1'b0;

            // long receiver hold-off while items keep coming
            if (p == 0)
                hold_off_pending = 1'b1;

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                send_item(FUNC_START, 8'($urandom()), 1'b0, '0);
                phase_items++;
                while (phase_q != CP_IDLE) begin
                    if ($urandom_range(0, 99) < 4) begin
                        // restart in the middle of a calibration
                        send_item(FUNC_START, 8'($urandom()), 1'b0, '0);
                    end else if ($urandom_range(0, 99) < 10) begin
                        send_item(FUNC_MEASURE, 8'($urandom()), 1'b0, '0);
                    end else begin
                        case (phase_q)
                            CP_FIRST, CP_REDUCE:
                                send_item(FUNC_MEASURE, ($urandom_range(0, 99) < 55) ?
                                          sample_at_or_above() : sample_below(), 1'b0, '0);
                            CP_REFMAX, CP_AMPLIFY:
                                send_item(FUNC_MEASURE, ($urandom_range(0, 99) < 55) ?
                                          sample_below() : sample_at_or_above(), 1'b0, '0);
                            default:
                                send_item(FUNC_MEASURE, ($urandom_range(0, 99) < 30) ?
                                          sample_below() : sample_at_or_above(), 1'b0, '0);
                        endcase
                    end
                    phase_items++;
                end
                // occasional measurement while idle
                if ($urandom_range(0, 99) < 20)
                    send_item(FUNC_MEASURE, 8'($urandom()), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb_card_detect_calibration_sequencer: clean");
        else
            $display("tb_card_detect_calibration_sequencer: errors");
        $finish;
    end

endmodule
